// ===== rtl/core/swm_pkg.sv =====
// swm_pkg: shared widths, types and helpers for the sliding window median unit.
// No dependencies; used by rtl/core/sliding_window_median_unit.sv.
`timescale 1ns / 1ps

package swm_pkg;

  // Window depth and sample width
  localparam int MAX_WINDOW   = 64;
  localparam int SAMPLE_BITS  = 32;
  localparam int WIN_BITS     = $clog2(MAX_WINDOW + 1);
  localparam int IDX_BITS     = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int RESET_WINDOW = 3;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic [WIN_BITS-1:0]           win_t;
  typedef logic [IDX_BITS-1:0]           idx_t;

  // Window size as used: zero acts as one, large values clamp to the depth
  function automatic win_t eff_size(input win_t raw);
    win_t w;
    w = raw;
    if (raw == '0) begin
      w = win_t'(1);
    end else if (raw > win_t'(MAX_WINDOW)) begin
      w = win_t'(MAX_WINDOW);
    end
    return w;
  endfunction

endpackage

// ===== rtl/core/sliding_window_median_unit.sv =====
// sliding_window_median_unit: lower-median filter over a signed sample stream.
// Depends on rtl/core/swm_pkg.sv (widths, types, window size clamp).
`timescale 1ns / 1ps

//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+------------------------------
//  s_      | in        | s_tvalid / s_tready    | s_tdata[31:0]  sample
//  m_      | out       | m_tvalid / m_tready    | m_tdata[31:0]  median
//  cfg_    | in        | cfg_valid / cfg_ready  | cfg_data[6:0]  window_size
//
//  One item per cycle sustained while the result register drains; the limit is the
//  combinational remove/compare/shift across the row of sorted cells.
//  Reset clears the fill count and sets window size 3; cells need no clearing.
//  A window size write restarts filling. Input is taken while the result
//  register is empty or being drained in the same cycle.

module sliding_window_median_unit (
  input  logic                          clk,
  input  logic                          rst,
  // sample stream, tdata: [31:0] sample
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [swm_pkg::SAMPLE_BITS-1:0] s_tdata,
  // median stream, tdata: [31:0] median
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [swm_pkg::SAMPLE_BITS-1:0] m_tdata,
  // window size register write
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [swm_pkg::WIN_BITS-1:0]  cfg_data
);

  localparam int N = swm_pkg::MAX_WINDOW;

  // Control registers
  swm_pkg::win_t    window_size;
  swm_pkg::win_t    fill_count;
  swm_pkg::win_t    fill_count_next;

  // Sorted cell row: value and age (samples arrived since) per cell
  swm_pkg::sample_t cell_val [N];
  swm_pkg::idx_t    cell_age [N];
  swm_pkg::sample_t val_next [N];
  swm_pkg::idx_t    age_next [N];

  // Per-cell working signals
  swm_pkg::sample_t r_val [N];
  swm_pkg::idx_t    r_age [N];
  logic [N-1:0]     del_hit;
  logic [N-1:0]     rm_before;
  logic [N-1:0]     le;

  swm_pkg::win_t    w;
  swm_pkg::win_t    keep_cnt;
  swm_pkg::idx_t    med_idx;
  swm_pkg::sample_t key;
  logic             full;
  logic             produce;
  logic             s_fire;
  logic             cfg_fire;

  assign w        = swm_pkg::eff_size(window_size);
  assign key      = swm_pkg::sample_t'(s_tdata);
  assign full     = (fill_count >= w);
  assign keep_cnt = full ? (w - swm_pkg::win_t'(1)) : fill_count;
  assign med_idx  = swm_pkg::idx_t'((w - swm_pkg::win_t'(1)) >> 1);
  assign produce  = full || ((fill_count + swm_pkg::win_t'(1)) == w);
  assign fill_count_next = full ? w : (fill_count + swm_pkg::win_t'(1));

  assign s_tready  = !m_tvalid || m_tready;
  assign s_fire    = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;

  // Remove the oldest cell (full window only), then insert the new item
  for (genvar gi = 0; gi < N; gi++) begin : g_cell
    assign del_hit[gi] = full && (swm_pkg::win_t'(gi) < fill_count) &&
                         (cell_age[gi] == swm_pkg::idx_t'(w - swm_pkg::win_t'(1)));
    assign rm_before[gi] = |del_hit[gi:0];

    // close the gap left by the removed cell
    if (gi < N - 1) begin : g_shift
      assign r_val[gi] = rm_before[gi] ? cell_val[gi+1] : cell_val[gi];
      assign r_age[gi] = rm_before[gi] ? cell_age[gi+1] : cell_age[gi];
    end else begin : g_last
      assign r_val[gi] = cell_val[gi];
      assign r_age[gi] = cell_age[gi];
    end

    // cells at or below the new item keep their place; equals stay ahead
    assign le[gi] = (swm_pkg::win_t'(gi) < keep_cnt) && !(r_val[gi] > key);

    if (gi == 0) begin : g_first
      assign val_next[gi] = le[gi] ? r_val[gi] : key;
      assign age_next[gi] = le[gi] ? (r_age[gi] + swm_pkg::idx_t'(1)) : '0;
    end else begin : g_rest
      assign val_next[gi] = le[gi]    ? r_val[gi] :
                            le[gi-1]  ? key       : r_val[gi-1];
      assign age_next[gi] = le[gi]    ? (r_age[gi] + swm_pkg::idx_t'(1)) :
                            le[gi-1]  ? '0 : (r_age[gi-1] + swm_pkg::idx_t'(1));
    end
  end

  // Cell row update
  always_ff @(posedge clk) begin
    if (s_fire) begin
      for (int i = 0; i < N; i++) begin
        cell_val[i] <= val_next[i];
        cell_age[i] <= age_next[i];
      end
    end
  end

  // Window size and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      window_size <= swm_pkg::win_t'(swm_pkg::RESET_WINDOW);
      fill_count  <= '0;
    end else if (cfg_fire) begin
      window_size <= cfg_data;
      fill_count  <= '0;
    end else if (s_fire) begin
      fill_count  <= fill_count_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s_fire && produce) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_fire && produce) begin
      m_tdata <= val_next[med_idx];
    end
  end

`ifndef SYNTHESIS
  // fill count never passes the window in use
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= w)
    else $error("fill count above window size");

  // a full window holds exactly one cell old enough to drop
  a_one_oldest: assert property (@(posedge clk) disable iff (rst)
    full |-> ($countones(del_hit) == 1))
    else $error("oldest cell not unique");

  // every item taken on a full window shows up as a result
  a_full_result: assert property (@(posedge clk) disable iff (rst)
    (s_fire && full) |=> m_tvalid)
    else $error("full window item gave no result");

  // a window size write restarts filling
  a_cfg_flush: assert property (@(posedge clk) disable iff (rst)
    cfg_fire |=> (fill_count == '0))
    else $error("window not flushed on size write");

  // the two lowest cells stay in ascending order
  a_sorted_head: assert property (@(posedge clk) disable iff (rst)
    (fill_count >= swm_pkg::win_t'(2)) |-> (cell_val[0] <= cell_val[1]))
    else $error("cell row out of order");
`endif

endmodule

// ===== sim/tb_sliding_window_median_unit.sv =====
// Self-checking testbench for sliding_window_median_unit: streams signed samples,
// predicts each lower median in-line and compares every median item in order.
// Depends on rtl/core/swm_pkg.sv and rtl/core/sliding_window_median_unit.sv.
`timescale 1ns / 1ps

module tb_sliding_window_median_unit;

  localparam int STALL_LIMIT = 4000;
  localparam int SETTLE_CYCLES = 4;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                            s_tvalid = 1'b0;
  logic                            s_tready;
  logic [swm_pkg::SAMPLE_BITS-1:0] s_tdata = '0;   // [31:0] sample
  logic                            m_tvalid;
  logic                            m_tready = 1'b0;
  logic [swm_pkg::SAMPLE_BITS-1:0] m_tdata;        // [31:0] median
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  swm_pkg::win_t                   cfg_data = '0;

  sliding_window_median_unit uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  // samples waiting to be sent, medians waiting to arrive
  swm_pkg::sample_t sample_q[$];
  swm_pkg::sample_t median_q[$];

  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int errors = 0;
  int stall_cnt = 0;

  // predictor state: arrival ring, ascending copy, fill level, oldest slot
  swm_pkg::sample_t age_slots[swm_pkg::MAX_WINDOW];
  swm_pkg::sample_t rank_slots[swm_pkg::MAX_WINDOW];
  int               fill_lvl = 0;
  int               oldest_slot = 0;
  swm_pkg::win_t    window_reg = swm_pkg::win_t'(swm_pkg::RESET_WINDOW);

  initial begin
    forever #2 clk = ~clk;
  end

  // window size in force: zero acts as one, large values clamp to the depth
  function automatic int active_window();
    int w;
    w = int'(window_reg);
    if (w < 1) w = 1;
    if (w > swm_pkg::MAX_WINDOW) w = swm_pkg::MAX_WINDOW;
    return w;
  endfunction

  // update the window with one sample and queue the median it yields
  task automatic predict_median(input swm_pkg::sample_t s);
    int w;
    int p;
    int i;
    w = active_window();
    if (fill_lvl >= w) begin
      p = (oldest_slot >= w) ? 0 : oldest_slot;
      // drop the oldest sample from the ranked list
      i = 0;
      while (i < w && rank_slots[i] != age_slots[p]) i++;
      for (int j = i; j + 1 < w; j++) rank_slots[j] = rank_slots[j + 1];
      // ranked insert into w-1 entries
      i = w - 1;
      while (i > 0 && rank_slots[i - 1] > s) begin
        rank_slots[i] = rank_slots[i - 1];
        i--;
      end
      rank_slots[i] = s;
      age_slots[p] = s;
      p++;
      oldest_slot = (p >= w) ? 0 : p;
      fill_lvl = w;
    end else begin
      i = fill_lvl;
      while (i > 0 && rank_slots[i - 1] > s) begin
        rank_slots[i] = rank_slots[i - 1];
        i--;
      end
      rank_slots[i] = s;
      age_slots[fill_lvl] = s;
      fill_lvl++;
      if (fill_lvl < w) return;
      oldest_slot = 0;
    end
    median_q = {median_q, rank_slots[(w - 1) / 2]};
  endtask

  // sample source: drives the next queued sample when the bus is free
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) predict_median(swm_pkg::sample_t'(s_tdata));
      if (!s_tvalid || s_tready) begin
        if (sample_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
          s_tvalid <= 1'b1;
          s_tdata  <= sample_q.pop_front();
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // median sink: random back-pressure, in-order compare
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (median_q.size() == 0) begin
          errors++;
          $display("%0t unexpected median item: expected none actual %0d",
                   $time, swm_pkg::sample_t'(m_tdata));
        end else if (swm_pkg::sample_t'(m_tdata) !== median_q[0]) begin
          errors++;
          $display("%0t median mismatch: expected %0d actual %0d",
                   $time, median_q[0], swm_pkg::sample_t'(m_tdata));
          void'(median_q.pop_front());
        end else begin
          void'(median_q.pop_front());
        end
      end
      m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // watchdog on cycles with no handshake of any kind
  always @(posedge clk) begin
    if (rst) begin
      stall_cnt <= 0;
    end else if ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
                 (cfg_valid && cfg_ready)) begin
      stall_cnt <= 0;
    end else if (stall_cnt >= STALL_LIMIT) begin
      $display("%0t watchdog: no progress for %0d cycles", $time, STALL_LIMIT);
      $display("TB_ERROR");
      $finish;
    end else begin
      stall_cnt <= stall_cnt + 1;
    end
  end

  // wait until every sample is taken and every median has arrived
  task automatic drain();
    do @(posedge clk);
    while (!(sample_q.size() == 0 && !s_tvalid && median_q.size() == 0));
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // write the window size register; a write restarts filling
  task automatic write_window(input int v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= swm_pkg::win_t'(v);
    do @(posedge clk);
    while (!cfg_ready);
    window_reg  = swm_pkg::win_t'(v);
    fill_lvl    = 0;
    oldest_slot = 0;
    cfg_valid <= 1'b0;
  endtask

  // mostly random words, some tiny values for ties, some extremes
  function automatic swm_pkg::sample_t rand_sample();
    case ($urandom_range(9))
      5, 6, 7: return swm_pkg::sample_t'($signed($urandom_range(6)) - 3);
      8: begin
        case ($urandom_range(3))
          0: return swm_pkg::sample_t'(32'h8000_0000);
          1: return swm_pkg::sample_t'(32'h7fff_ffff);
          2: return swm_pkg::sample_t'(0);
          default: return swm_pkg::sample_t'(-1);
        endcase
      end
      default: return swm_pkg::sample_t'($urandom);
    endcase
  endfunction

  task automatic feed(input int n);
    repeat (n) sample_q = {sample_q, rand_sample()};
    drain();
  endtask

  int win_plan[9]  = '{1, 2, 64, 127, 65, 0, 7, 16, 0};
  int item_plan[9] = '{60, 60, 200, 130, 100, 40, 100, 100, 60};

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    tx_idle_pct = 9;
    rx_idle_pct = 51;

    // reset window of three: extremes, ties, sign boundary
    sample_q = '{swm_pkg::sample_t'(32'h8000_0000), swm_pkg::sample_t'(32'h7fff_ffff),
                 swm_pkg::sample_t'(0), swm_pkg::sample_t'(-1), swm_pkg::sample_t'(1),
                 swm_pkg::sample_t'(32'h7fff_ffff), swm_pkg::sample_t'(32'h7fff_ffff),
                 swm_pkg::sample_t'(32'h8000_0000)};
    drain();

    // size zero behaves as a window of one
    write_window(0);
    sample_q = '{swm_pkg::sample_t'(32'h7fff_ffff), swm_pkg::sample_t'(32'h8000_0000),
                 swm_pkg::sample_t'(-1)};
    drain();

    // partial fill, then a rewrite that flushes it
    write_window(5);
    sample_q = '{swm_pkg::sample_t'(9), swm_pkg::sample_t'(-9)};
    drain();
    write_window(2);
    sample_q = '{swm_pkg::sample_t'(7), swm_pkg::sample_t'(7), swm_pkg::sample_t'(-7),
                 swm_pkg::sample_t'(32'h8000_0000)};
    drain();

    // random phases across window sizes and idle patterns
    for (int ph = 0; ph < 9; ph++) begin
      if (ph < 3) begin
        tx_idle_pct = 9;
        rx_idle_pct = 51;
      end else if (ph < 6) begin
        tx_idle_pct = 51;
        rx_idle_pct = 9;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      write_window((ph == 8) ? $urandom_range(20, 1) : win_plan[ph]);
      // pause the source mid-stream until all medians are in
      feed(item_plan[ph] / 2);
      feed(item_plan[ph] - item_plan[ph] / 2);
    end

    drain();
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
